// File: rtl/core/assert_macros.svh
// assertion macros used by the checker file
// ARFF_ASSERT expects clk and rst_n in scope, ARFF_ASSERT_ALWAYS only clk
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ARFF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define ARFF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/arff_pkg.sv
// shared types and constants of the atlas rectangle first-fit allocator
// no dependencies
package arff_pkg;

    localparam int CFG_W       = 7;
    localparam int PIX_W       = 11;
    localparam int POS_W       = 10;
    localparam int SQ_W        = 12;  // size in squares and pixel sums up to 2047 + 255
    localparam int RECIP_SHIFT = 24;
    localparam int IN_DATA_W   = 24;
    localparam int OUT_DATA_W  = 24;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'd1;
    localparam logic [CFG_W-1:0]     GRID_RESET      = 7'd64;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SIZE,
        ST_CHECK,
        ST_ROWS,
        ST_ROWS_WAIT,
        ST_DIL_INIT,
        ST_DIL,
        ST_FIND_GROUP,
        ST_FIND_PICK,
        ST_DECIDE,
        ST_MARK,
        ST_MARK_WAIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic clear_map;
        logic load_req;
        logic size;
        logic scan_init;
        logic row_init;
        logic y_inc;
        logic rd_issue;
        logic mark;
        logic dil_init;
        logic dil_step;
        logic find_group;
        logic find_pick;
        logic rect_load;
        logic res_set;
        logic res_found;
        logic res_pos;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic zero_size;
        logic too_big;
        logic rows_last;
        logic dil_done;
        logic y_last;
        logic hit;
        logic out_free;
    } sts_t;

endpackage

// File: rtl/core/arff_ctrl.sv
// sequencing state machine of the allocator
// depends on arff_pkg; drives arff_dpath through cmd_t and reads sts_t
module arff_ctrl
    import arff_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic in_op,
    output logic in_ready,
    output cmd_t cmd,
    input  sts_t sts
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_op == OP_CLEAR)
                    begin
                        cmd.clear_map = 1'b1;
                    end
                    else
                    begin
                        cmd.load_req = 1'b1;
                        state_next   = ST_SIZE;
                    end
                end
            end
            ST_SIZE:
            begin
                cmd.size   = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                priority if (sts.zero_size)
                begin
                    cmd.res_set   = 1'b1;
                    cmd.res_found = 1'b1;
                    state_next    = ST_DONE;
                end
                else if (sts.too_big)
                begin
                    cmd.res_set = 1'b1;
                    state_next  = ST_DONE;
                end
                else
                begin
                    cmd.scan_init = 1'b1;
                    cmd.row_init  = 1'b1;
                    state_next    = ST_ROWS;
                end
            end
            ST_ROWS:
            begin
                cmd.rd_issue = 1'b1;
                if (sts.rows_last)
                begin
                    state_next = ST_ROWS_WAIT;
                end
            end
            ST_ROWS_WAIT:
            begin
                // last row folds into the accumulator here
                state_next = ST_DIL_INIT;
            end
            ST_DIL_INIT:
            begin
                cmd.dil_init = 1'b1;
                state_next   = ST_DIL;
            end
            ST_DIL:
            begin
                if (sts.dil_done)
                begin
                    state_next = ST_FIND_GROUP;
                end
                else
                begin
                    cmd.dil_step = 1'b1;
                end
            end
            ST_FIND_GROUP:
            begin
                cmd.find_group = 1'b1;
                state_next     = ST_FIND_PICK;
            end
            ST_FIND_PICK:
            begin
                cmd.find_pick = 1'b1;
                state_next    = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                priority if (sts.hit)
                begin
                    cmd.rect_load = 1'b1;
                    cmd.row_init  = 1'b1;
                    state_next    = ST_MARK;
                end
                else if (sts.y_last)
                begin
                    cmd.res_set = 1'b1;
                    state_next  = ST_DONE;
                end
                else
                begin
                    cmd.y_inc    = 1'b1;
                    cmd.row_init = 1'b1;
                    state_next   = ST_ROWS;
                end
            end
            ST_MARK:
            begin
                cmd.rd_issue = 1'b1;
                cmd.mark     = 1'b1;
                if (sts.rows_last)
                begin
                    state_next = ST_MARK_WAIT;
                end
            end
            ST_MARK_WAIT:
            begin
                cmd.res_set   = 1'b1;
                cmd.res_found = 1'b1;
                cmd.res_pos   = 1'b1;
                state_next    = ST_DONE;
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/arff_dpath.sv
// datapath: occupancy rows, row accumulator, dilation, first-free search, result register
// depends on arff_pkg; sequenced by arff_ctrl
module arff_dpath
    import arff_pkg::*;
#(
    parameter int SQUARE_SIDE     = 16,
    parameter int MAX_GRID_WIDTH  = 64,
    parameter int MAX_GRID_HEIGHT = 64
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cmd_t             cmd,
    output sts_t             sts,
    input  logic             cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic [PIX_W-1:0] req_width_pixels,
    input  logic [PIX_W-1:0] req_height_pixels,
    input  logic             out_ready,
    output logic             out_valid,
    output logic             found,
    output logic [POS_W-1:0] x_pixel,
    output logic [POS_W-1:0] y_pixel
);

    localparam int W     = MAX_GRID_WIDTH;
    localparam int H     = MAX_GRID_HEIGHT;
    localparam int CA    = (W > 1) ? $clog2(W) : 1;
    localparam int RA    = (H > 1) ? $clog2(H) : 1;
    localparam int NG    = (W + 7) / 8;
    localparam int PADW  = NG * 8;
    localparam int MUL_W = SQ_W + RECIP_SHIFT + 1;
    localparam logic [RECIP_SHIFT:0] RECIP =
        (RECIP_SHIFT + 1)'(((1 << RECIP_SHIFT) + SQUARE_SIDE - 1) / SQUARE_SIDE);
    localparam logic [W-1:0]    TOP_BIT  = W'(1) << (W - 1);
    localparam logic [PADW-1:0] PAD_FILL = ~PADW'({W{1'b1}});

    // configuration
    logic [CFG_W-1:0] cfg_w_reg;
    logic [CFG_W-1:0] cfg_h_reg;
    logic [SQ_W-1:0]  gw;
    logic [SQ_W-1:0]  gh;

    // request
    logic [PIX_W-1:0] pw_reg;
    logic [PIX_W-1:0] ph_reg;
    logic [SQ_W-1:0]  pw_up;
    logic [SQ_W-1:0]  ph_up;
    logic [MUL_W-1:0] prod_w;
    logic [MUL_W-1:0] prod_h;
    logic [SQ_W-1:0]  w_reg;
    logic [SQ_W-1:0]  h_reg;

    // scan counters
    logic [RA-1:0] y_reg;
    logic [RA:0]   k_reg;
    logic [CA:0]   c_reg;
    logic [RA:0]   addr_sum;
    logic [RA-1:0] rd_addr;

    // occupancy rows, a row never written since clear reads as free
    logic [W-1:0]  mem [H];
    logic [H-1:0]  vld_reg;
    logic [W-1:0]  rd_q_reg;
    logic          rd_vld_reg;
    logic [W-1:0]  rd_row;
    logic          pend_reg;
    logic          pend_mark_reg;
    logic [RA-1:0] wr_addr_reg;

    // row accumulator and dilation
    logic [W-1:0] acc_reg;
    logic [W-1:0] base_reg;
    logic [W-1:0] oob;
    logic [W-1:0] rect_reg;
    logic [W-1:0] low_mask;

    // first-free search
    logic [PADW-1:0] pad;
    logic [NG-1:0]   grp_free_next;
    logic [2:0]      grp_idx_next [NG];
    logic [NG-1:0]   grp_free_reg;
    logic [2:0]      grp_idx_reg [NG];
    logic            pick_hit;
    logic [CA-1:0]   pick_x;
    logic            hit_reg;
    logic [CA-1:0]   x_reg;

    // result
    logic            res_found_reg;
    logic [CA-1:0]   res_x_reg;
    logic [RA-1:0]   res_y_reg;
    logic [CA+8:0]   x_scaled;
    logic [RA+8:0]   y_scaled;
    logic            out_valid_reg;
    logic            out_found_reg;
    logic [POS_W-1:0] out_x_reg;
    logic [POS_W-1:0] out_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_w_reg <= GRID_RESET;
            cfg_h_reg <= GRID_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_GRID_WIDTH:  cfg_w_reg <= cfg_wdata;
                REG_GRID_HEIGHT: cfg_h_reg <= cfg_wdata;
            endcase
        end
    end

    // saturate to the built grid
    assign gw = (SQ_W'(cfg_w_reg) > SQ_W'(W)) ? SQ_W'(W) : SQ_W'(cfg_w_reg);
    assign gh = (SQ_W'(cfg_h_reg) > SQ_W'(H)) ? SQ_W'(H) : SQ_W'(cfg_h_reg);

    // round up to squares by reciprocal multiply, exact for pixel sums below 4096
    assign pw_up  = SQ_W'(pw_reg) + SQ_W'(SQUARE_SIDE - 1);
    assign ph_up  = SQ_W'(ph_reg) + SQ_W'(SQUARE_SIDE - 1);
    assign prod_w = MUL_W'(pw_up) * MUL_W'(RECIP);
    assign prod_h = MUL_W'(ph_up) * MUL_W'(RECIP);

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            pw_reg <= req_width_pixels;
            ph_reg <= req_height_pixels;
        end
        if (cmd.size)
        begin
            w_reg <= prod_w[RECIP_SHIFT +: SQ_W];
            h_reg <= prod_h[RECIP_SHIFT +: SQ_W];
        end
    end

    assign addr_sum = (RA + 1)'(y_reg) + k_reg;
    assign rd_addr  = addr_sum[RA-1:0];
    assign rd_row   = rd_vld_reg ? rd_q_reg : '0;

    always_ff @(posedge clk)
    begin
        if (cmd.scan_init)
        begin
            y_reg <= '0;
        end
        else if (cmd.y_inc)
        begin
            y_reg <= y_reg + RA'(1);
        end
        if (cmd.row_init)
        begin
            k_reg <= '0;
        end
        else if (cmd.rd_issue)
        begin
            k_reg <= k_reg + (RA + 1)'(1);
        end
        if (cmd.dil_init)
        begin
            c_reg <= (CA + 1)'(1);
        end
        else if (cmd.dil_step)
        begin
            c_reg <= c_reg + (CA + 1)'(1);
        end
    end

    // row memory: a read is issued, then merged or written back in the cycle after
    always_ff @(posedge clk)
    begin
        if (pend_mark_reg)
        begin
            mem[wr_addr_reg] <= rd_row | rect_reg;
        end
        if (cmd.rd_issue)
        begin
            rd_q_reg    <= mem[rd_addr];
            rd_vld_reg  <= vld_reg[rd_addr];
            wr_addr_reg <= rd_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            pend_reg      <= 1'b0;
            pend_mark_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= cmd.rd_issue;
            pend_mark_reg <= cmd.rd_issue & cmd.mark;
            if (cmd.clear_map)
            begin
                vld_reg <= '0;
            end
            else if (pend_mark_reg)
            begin
                vld_reg[wr_addr_reg] <= 1'b1;
            end
        end
    end

    // columns past the configured width count as taken
    always_comb
    begin
        for (int i = 0; i < W; i++)
        begin
            oob[i]      = (SQ_W'(i) >= gw);
            low_mask[i] = (SQ_W'(i) < w_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        priority if (cmd.row_init)
        begin
            acc_reg <= oob;
        end
        else if (pend_reg && !pend_mark_reg)
        begin
            acc_reg <= acc_reg | rd_row;
        end
        else if (cmd.dil_step)
        begin
            // origin blocked if any of the next w columns is taken
            acc_reg <= base_reg | (acc_reg >> 1) | TOP_BIT;
        end
        if (cmd.dil_init)
        begin
            base_reg <= acc_reg;
        end
        if (cmd.rect_load)
        begin
            rect_reg <= low_mask << x_reg;
        end
    end

    // two-level search for the lowest free origin
    assign pad = PADW'(acc_reg) | PAD_FILL;

    always_comb
    begin
        for (int g = 0; g < NG; g++)
        begin
            grp_free_next[g] = ~&pad[g*8 +: 8];
            grp_idx_next[g]  = 3'd0;
            for (int j = 7; j >= 0; j--)
            begin
                if (!pad[g*8 + j])
                begin
                    grp_idx_next[g] = 3'(j);
                end
            end
        end
    end

    always_comb
    begin
        pick_hit = 1'b0;
        pick_x   = '0;
        for (int g = NG - 1; g >= 0; g--)
        begin
            if (grp_free_reg[g])
            begin
                pick_hit = 1'b1;
                pick_x   = CA'((g * 8) + int'(grp_idx_reg[g]));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.find_group)
        begin
            grp_free_reg <= grp_free_next;
            grp_idx_reg  <= grp_idx_next;
        end
        if (cmd.find_pick)
        begin
            hit_reg <= pick_hit;
            x_reg   <= pick_x;
        end
        if (cmd.res_set)
        begin
            res_found_reg <= cmd.res_found;
            res_x_reg     <= cmd.res_pos ? x_reg : '0;
            res_y_reg     <= cmd.res_pos ? y_reg : '0;
        end
    end

    assign x_scaled = (CA + 9)'(res_x_reg) * (CA + 9)'(SQUARE_SIDE);
    assign y_scaled = (RA + 9)'(res_y_reg) * (RA + 9)'(SQUARE_SIDE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_found_reg <= res_found_reg;
            out_x_reg     <= x_scaled[POS_W-1:0];
            out_y_reg     <= y_scaled[POS_W-1:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign found     = out_found_reg;
    assign x_pixel   = out_x_reg;
    assign y_pixel   = out_y_reg;

    assign sts.zero_size = (w_reg == '0) || (h_reg == '0);
    assign sts.too_big   = (w_reg > gw) || (h_reg > gh);
    assign sts.rows_last = (SQ_W'(k_reg) + SQ_W'(1)) == h_reg;
    assign sts.dil_done  = SQ_W'(c_reg) >= w_reg;
    assign sts.y_last    = (SQ_W'(y_reg) + h_reg) >= gh;
    assign sts.hit       = hit_reg;
    assign sts.out_free  = !out_valid_reg || out_ready;

endmodule

// File: rtl/core/atlas_rect_first_fit_alloc_top.sv
// allocate: zero-area or oversized requests skip the scan and go from the check state to done
// scan: each candidate row y takes h row reads, a dilation over w columns and a search,
//   a hit adds a read-modify-write of the h rows of the rectangle on the row memory
// one item at a time; the next item is taken once the result sits in the output register
// clear: no result; reset and clear empty the map at once through per-row valid flops
// config registers come out of reset at 64 x 64 squares
module atlas_rect_first_fit_alloc_top
    import arff_pkg::*;
#(
    parameter int SQUARE_SIDE     = 16,
    parameter int MAX_GRID_WIDTH  = 64,
    parameter int MAX_GRID_HEIGHT = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // req_width_pixels[10:0], req_height_pixels[21:11]
    input  logic                  s_tuser,   // op
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // x_pixel[9:0], y_pixel[19:10]
    output logic                  m_tuser    // found
);

    cmd_t             cmd;
    sts_t             sts;
    logic [POS_W-1:0] x_pixel;
    logic [POS_W-1:0] y_pixel;

    arff_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_op    (s_tuser),
        .in_ready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    arff_dpath #(
        .SQUARE_SIDE     (SQUARE_SIDE),
        .MAX_GRID_WIDTH  (MAX_GRID_WIDTH),
        .MAX_GRID_HEIGHT (MAX_GRID_HEIGHT)
    ) u_dpath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .cfg_we            (cfg_we),
        .cfg_addr          (cfg_addr),
        .cfg_wdata         (cfg_wdata),
        .req_width_pixels  (s_tdata[PIX_W-1:0]),
        .req_height_pixels (s_tdata[2*PIX_W-1:PIX_W]),
        .out_ready         (m_tready),
        .out_valid         (m_tvalid),
        .found             (m_tuser),
        .x_pixel           (x_pixel),
        .y_pixel           (y_pixel)
    );

    assign m_tdata = {{(OUT_DATA_W - 2*POS_W){1'b0}}, y_pixel, x_pixel};

endmodule

// File: rtl/core/arff_checker.sv
// port-level checks for the allocator top level, bound to it below
// depends on arff_pkg and assert_macros.svh
`include "assert_macros.svh"

module arff_checker
    import arff_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  s_tuser,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  m_tuser
);

    `ARFF_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
    `ARFF_ASSERT_ALWAYS(a_rst_quiet, !rst_n |-> !m_tvalid, "result shown during reset")
    `ARFF_ASSERT(a_alloc_busy, s_tvalid && s_tready && (s_tuser == OP_ALLOC) |=> !s_tready, "item taken while an allocation runs")
    `ARFF_ASSERT(a_miss_zero, m_tvalid && !m_tuser |-> m_tdata == '0, "miss carries a nonzero origin")

endmodule

bind atlas_rect_first_fit_alloc_top arff_checker u_arff_checker (.*);

// File: bench/tb_top.sv
// self-checking bench for the atlas rectangle first-fit allocator: a queue-fed driver,
// a checking monitor and a bitmap predictor of its own
// depends on arff_pkg and atlas_rect_first_fit_alloc_top
module tb_top;
    import arff_pkg::*;

    localparam int SQUARE_PIX = 16;
    localparam int MAX_W      = 64;
    localparam int MAX_H      = 64;
    localparam int PHASES     = 12;
    localparam int PHASE_REQS = 142;

    typedef struct packed {
        logic             op;
        logic [PIX_W-1:0] wpix;
        logic [PIX_W-1:0] hpix;
    } alloc_req_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] x_pix;
        logic [POS_W-1:0] y_pix;
    } placement_t;

    typedef enum {PACE_FULL, PACE_SLOW_SRC, PACE_SLOW_SINK, PACE_BOTH} pace_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b1;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;  // req_width_pixels[10:0], req_height_pixels[21:11]
    logic                  s_tuser   = 1'b0; // op
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr  = '0;
    logic [CFG_W-1:0]      cfg_wdata = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;          // x_pixel[9:0], y_pixel[19:10]
    logic                  m_tuser;          // found

    alloc_req_t  req_queue[$];
    placement_t  placements_due[$];
    alloc_req_t  in_flight;
    pace_t       pace = PACE_FULL;
    int          mismatch_count = 0;

    // predictor state
    bit               occ_map [MAX_H][MAX_W];
    logic [CFG_W-1:0] grid_w_cfg = GRID_RESET;
    logic [CFG_W-1:0] grid_h_cfg = GRID_RESET;

    int phase_w [PHASES] = '{16, 8, 64, 40, 3, 64, 127, 24, 64, 12, 1, 32};
    int phase_h [PHASES] = '{16, 40, 64, 8, 64, 2, 20, 24, 64, 100, 64, 32};

    atlas_rect_first_fit_alloc_top #(
        .SQUARE_SIDE     (SQUARE_PIX),
        .MAX_GRID_WIDTH  (MAX_W),
        .MAX_GRID_HEIGHT (MAX_H)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        #1_000_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic int sat_grid(input logic [CFG_W-1:0] cfg, input int limit);
        return (int'(cfg) > limit) ? limit : int'(cfg);
    endfunction

    function automatic bit area_free(input int x0, input int y0, input int w, input int h);
        for (int r = 0; r < h; r++)
            for (int c = 0; c < w; c++)
                if (occ_map[y0 + r][x0 + c])
                    return 1'b0;
        return 1'b1;
    endfunction

    // first fit, row by row then left to right; an allocation's result goes to placements_due, a clear gives none
    task automatic place_rect(input alloc_req_t req);
        placement_t res;
        int gw, gh, w, h, x, y;
        bit placed;
        res = '0;
        placed = 1'b0;
        if (req.op == OP_CLEAR)
        begin
            for (y = 0; y < MAX_H; y++)
                for (x = 0; x < MAX_W; x++)
                    occ_map[y][x] = 1'b0;
            return;
        end
        gw = sat_grid(grid_w_cfg, MAX_W);
        gh = sat_grid(grid_h_cfg, MAX_H);
        w = (int'(req.wpix) + SQUARE_PIX - 1) / SQUARE_PIX;
        h = (int'(req.hpix) + SQUARE_PIX - 1) / SQUARE_PIX;
        if (w == 0 || h == 0)
            res.found = 1'b1;
        else if (w <= gw && h <= gh)
        begin
            for (y = 0; y + h <= gh && !placed; y++)
            begin
                for (x = 0; x + w <= gw && !placed; x++)
                begin
                    if (area_free(x, y, w, h))
                    begin
                        for (int r = 0; r < h; r++)
                            for (int c = 0; c < w; c++)
                                occ_map[y + r][x + c] = 1'b1;
                        placed = 1'b1;
                        res.found = 1'b1;
                        res.x_pix = POS_W'(x * SQUARE_PIX);
                        res.y_pix = POS_W'(y * SQUARE_PIX);
                    end
                end
            end
        end
        placements_due.push_back(res);
    endtask

    function automatic logic [PIX_W-1:0] pix_for(input int squares);
        return PIX_W'((squares - 1) * SQUARE_PIX + $urandom_range(1, SQUARE_PIX));
    endfunction

    // mostly fitting rectangles sized to the grid, plus clears, zero areas and wide sizes
    function automatic alloc_req_t random_req();
        alloc_req_t req;
        int pick, wl, hl;
        pick = $urandom_range(99);
        wl = $urandom_range(1) ? sat_grid(grid_w_cfg, MAX_W) / 2 : sat_grid(grid_w_cfg, MAX_W) / 6;
        hl = $urandom_range(1) ? sat_grid(grid_h_cfg, MAX_H) / 2 : sat_grid(grid_h_cfg, MAX_H) / 6;
        if (wl < 1)
            wl = 1;
        if (hl < 1)
            hl = 1;
        req.op = OP_ALLOC;
        req.wpix = pix_for($urandom_range(1, wl));
        req.hpix = pix_for($urandom_range(1, hl));
        if (pick < 4)
            req.op = OP_CLEAR;
        else if (pick < 9)
        begin
            if ($urandom_range(1))
                req.wpix = '0;
            else
                req.hpix = '0;
        end
        else if (pick < 14)
        begin
            req.wpix = PIX_W'($urandom_range(2047));
            req.hpix = PIX_W'($urandom_range(2047));
        end
        return req;
    endfunction

    function automatic bit source_gap();
        case (pace)
            PACE_SLOW_SRC: return $urandom_range(99) < 81;
            PACE_BOTH:     return $urandom_range(99) < 24;
            default:       return 1'b0;
        endcase
    endfunction

    function automatic bit sink_stall();
        case (pace)
            PACE_SLOW_SINK: return $urandom_range(99) < 81;
            PACE_BOTH:      return $urandom_range(99) < 24;
            default:        return 1'b0;
        endcase
    endfunction

    task automatic log_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s", msg);
    endtask

    task automatic queue_req(input logic op, input int wpix, input int hpix);
        alloc_req_t req;
        req.op = op;
        req.wpix = PIX_W'(wpix);
        req.hpix = PIX_W'(hpix);
        req_queue.push_back(req);
    endtask

    // a trailing clear gives no result, so keep waiting after the last one
    task automatic wait_idle();
        while (req_queue.size() != 0 || s_tvalid || placements_due.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic set_grid(input int w, input int h);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_GRID_WIDTH;
        cfg_wdata <= CFG_W'(w);
        @(posedge clk);
        cfg_addr  <= REG_GRID_HEIGHT;
        cfg_wdata <= CFG_W'(h);
        @(posedge clk);
        cfg_we    <= 1'b0;
        grid_w_cfg = CFG_W'(w);
        grid_h_cfg = CFG_W'(h);
    endtask

    // driver: predicts on each input transfer, then offers the next pending request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
                place_rect(in_flight);
            if (!s_tvalid || s_tready)
            begin
                if (req_queue.size() != 0 && !source_gap())
                begin
                    in_flight = req_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {{(IN_DATA_W - 2 * PIX_W){1'b0}}, in_flight.hpix, in_flight.wpix};
                    s_tuser  <= in_flight.op;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // monitor: every output transfer against the oldest expected placement
    always @(posedge clk or negedge rst_n)
    begin
        placement_t got, want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.found = m_tuser;
                got.x_pix = m_tdata[POS_W-1:0];
                got.y_pix = m_tdata[2*POS_W-1:POS_W];
                if (placements_due.size() == 0)
                    log_failure($sformatf("unexpected result: found=%0d x=%0d y=%0d",
                                          got.found, got.x_pix, got.y_pix));
                else
                begin
                    want = placements_due.pop_front();
                    if (got !== want)
                        log_failure($sformatf(
                            "mismatch: expected found=%0d x=%0d y=%0d, got found=%0d x=%0d y=%0d",
                            want.found, want.x_pix, want.y_pix,
                            got.found, got.x_pix, got.y_pix));
                end
            end
            m_tready <= !sink_stall();
        end
    end

    initial
    begin
        int p;
        int k;
        // a real falling edge so the asynchronous reset reaches every flop that has one
        rst_n <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset grid of 64 x 64: zero areas, a full-map rectangle, oversize, clear with sizes
        queue_req(OP_ALLOC, 0, 0);
        queue_req(OP_ALLOC, 0, 1024);
        queue_req(OP_ALLOC, 1024, 0);
        queue_req(OP_ALLOC, 1024, 1024);
        queue_req(OP_ALLOC, 1, 1);
        queue_req(OP_CLEAR, 2047, 2047);
        queue_req(OP_ALLOC, 2047, 16);
        queue_req(OP_ALLOC, 1, 1);
        queue_req(OP_ALLOC, 17, 1);
        queue_req(OP_ALLOC, 1008, 16);
        queue_req(OP_ALLOC, 16, 1009);
        wait_idle();

        // registers above the maximum saturate
        set_grid(127, 127);
        queue_req(OP_CLEAR, 0, 0);
        queue_req(OP_ALLOC, 1024, 1024);
        queue_req(OP_ALLOC, 1, 1);
        wait_idle();

        // empty grid: only zero areas succeed
        set_grid(0, 5);
        queue_req(OP_ALLOC, 16, 16);
        queue_req(OP_ALLOC, 0, 16);
        queue_req(OP_ALLOC, 1, 0);
        wait_idle();
        set_grid(64, 0);
        queue_req(OP_ALLOC, 1, 1);
        wait_idle();

        // single square, shrunk without clearing the marks
        set_grid(1, 1);
        queue_req(OP_ALLOC, 1, 1);
        queue_req(OP_CLEAR, 0, 0);
        queue_req(OP_ALLOC, 1, 1);
        queue_req(OP_ALLOC, 1, 1);
        queue_req(OP_ALLOC, 17, 1);
        wait_idle();

        for (p = 0; p < PHASES; p++)
        begin
            set_grid(phase_w[p], phase_h[p]);
            pace = pace_t'(p % 4);
            for (k = 0; k < PHASE_REQS; k++)
                req_queue.push_back(random_req());
            wait_idle();
        end

        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
